>>> design/rsc_pkg.sv
package rsc_pkg;

  // field widths
  localparam int LOAD_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int FUNC_W    = 2;

  // exact widths of intermediate sums before clamping
  localparam int LOAD_WIDE = LOAD_BITS + 1;
  localparam int WIDE_BITS = TIME_BITS + 2;

  // stream packing
  localparam int IN_BITS    = 2 * LOAD_BITS + 6 * TIME_BITS - 1;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * LOAD_BITS + 4 * TIME_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_PREPEND = 2'd2
  } func_t;

  // segment summary, lowest field in the lowest bits
  typedef struct packed {
    logic                        ok;
    logic signed [TIME_BITS-1:0] lb;
    logic signed [TIME_BITS-1:0] ef;
    logic        [TIME_BITS-2:0] dur;
    logic        [TIME_BITS-1:0] distance;
    logic signed [LOAD_BITS-1:0] peak;
    logic signed [LOAD_BITS-1:0] load;
  } seg_t;

  // one input item: segment plus joining edge
  typedef struct packed {
    logic [TIME_BITS-1:0] link_dist;
    logic [TIME_BITS-2:0] link_dur;
    seg_t                 seg;
  } link_item_t;

  // input register contents handed to the datapath
  typedef struct packed {
    logic       valid;
    func_t      func;
    link_item_t item;
  } stage_t;

  function automatic logic signed [LOAD_WIDE-1:0] sext_load(
    input logic signed [LOAD_BITS-1:0] v);
    return {v[LOAD_BITS-1], v};
  endfunction

  function automatic logic signed [WIDE_BITS-1:0] sext_time(
    input logic signed [TIME_BITS-1:0] v);
    return {{(WIDE_BITS-TIME_BITS){v[TIME_BITS-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_BITS-1:0] zext_dur(
    input logic [TIME_BITS-2:0] v);
    return {{(WIDE_BITS-TIME_BITS+1){1'b0}}, v};
  endfunction

  function automatic logic [WIDE_BITS-1:0] zext_dist(input logic [TIME_BITS-1:0] v);
    return {{(WIDE_BITS-TIME_BITS){1'b0}}, v};
  endfunction

  // clamp to signed load range
  function automatic logic signed [LOAD_BITS-1:0] sat_load(
    input logic signed [LOAD_WIDE-1:0] v);
    logic signed [LOAD_BITS-1:0] r;
    if (v[LOAD_WIDE-1] == v[LOAD_BITS-1]) begin
      r = v[LOAD_BITS-1:0];
    end else if (v[LOAD_WIDE-1]) begin
      r = {1'b1, {(LOAD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(LOAD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp to signed time range
  function automatic logic signed [TIME_BITS-1:0] sat_time(
    input logic signed [WIDE_BITS-1:0] v);
    logic signed [TIME_BITS-1:0] r;
    if ((&v[WIDE_BITS-1:TIME_BITS-1]) || !(|v[WIDE_BITS-1:TIME_BITS-1])) begin
      r = v[TIME_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      r = {1'b1, {(TIME_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(TIME_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp nonnegative sums to the distance range
  function automatic logic [TIME_BITS-1:0] sat_dist(input logic [WIDE_BITS-1:0] v);
    logic [TIME_BITS-1:0] r;
    if (|v[WIDE_BITS-1:TIME_BITS]) begin
      r = {TIME_BITS{1'b1}};
    end else begin
      r = v[TIME_BITS-1:0];
    end
    return r;
  endfunction

  // clamp nonnegative sums to the duration range
  function automatic logic [TIME_BITS-2:0] sat_dur(input logic [WIDE_BITS-1:0] v);
    logic [TIME_BITS-2:0] r;
    if (|v[WIDE_BITS-1:TIME_BITS-1]) begin
      r = {(TIME_BITS-1){1'b1}};
    end else begin
      r = v[TIME_BITS-2:0];
    end
    return r;
  endfunction

endpackage

>>> design/rsc_in_stage.sv
module rsc_in_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // lsb up: item_load, item_peak_load, item_distance, item_duration,
  // item_earliest_finish, item_latest_begin, item_window_ok,
  // edge_duration, edge_distance, zero pad
  input  logic [rsc_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [rsc_pkg::FUNC_W-1:0]     s_tuser,
  input  logic                           take,
  output rsc_pkg::stage_t                stg
);

  logic                valid;
  rsc_pkg::func_t      func;
  rsc_pkg::link_item_t item;

  // free when empty or when the held beat moves on this cycle
  assign s_tready = !valid || take;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func <= rsc_pkg::func_t'(s_tuser);
      item <= rsc_pkg::link_item_t'(s_tdata[rsc_pkg::IN_BITS-1:0]);
    end
  end

  assign stg = '{valid: valid, func: func, item: item};

endmodule

>>> design/rsc_join.sv
module rsc_join (
  input  rsc_pkg::func_t      func,
  input  rsc_pkg::link_item_t item,
  input  rsc_pkg::seg_t       kept,
  output rsc_pkg::seg_t       next_seg
);

  rsc_pkg::seg_t a;
  rsc_pkg::seg_t b;
  rsc_pkg::seg_t joined;

  logic signed [rsc_pkg::LOAD_WIDE-1:0] load_sum;
  logic signed [rsc_pkg::LOAD_WIDE-1:0] peak_alt;
  logic signed [rsc_pkg::LOAD_WIDE-1:0] peak_a;
  logic signed [rsc_pkg::WIDE_BITS-1:0] ef_arrive;
  logic signed [rsc_pkg::WIDE_BITS-1:0] ef_sum;
  logic signed [rsc_pkg::WIDE_BITS-1:0] ef_b;
  logic signed [rsc_pkg::WIDE_BITS-1:0] lb_a;
  logic signed [rsc_pkg::WIDE_BITS-1:0] lb_b;
  logic signed [rsc_pkg::WIDE_BITS-1:0] lb_diff;
  logic        [rsc_pkg::WIDE_BITS-1:0] dist_sum;
  logic        [rsc_pkg::WIDE_BITS-1:0] dur_sum;

  // order the two segments: prepend puts the item first
  always_comb begin
    if (func == rsc_pkg::FUNC_PREPEND) begin
      a = item.seg;
      b = kept;
    end else begin
      a = kept;
      b = item.seg;
    end
  end

  // a then b across the joining edge, exact sums then clamp
  always_comb begin
    load_sum  = rsc_pkg::sext_load(a.load) + rsc_pkg::sext_load(b.load);
    peak_alt  = rsc_pkg::sext_load(a.load) + rsc_pkg::sext_load(b.peak);
    peak_a    = rsc_pkg::sext_load(a.peak);
    ef_arrive = rsc_pkg::sext_time(a.ef) + rsc_pkg::zext_dur(item.link_dur);
    ef_sum    = ef_arrive + rsc_pkg::zext_dur(b.dur);
    ef_b      = rsc_pkg::sext_time(b.ef);
    lb_a      = rsc_pkg::sext_time(a.lb);
    lb_b      = rsc_pkg::sext_time(b.lb);
    lb_diff   = lb_b - rsc_pkg::zext_dur(item.link_dur) - rsc_pkg::zext_dur(a.dur);
    dist_sum  = rsc_pkg::zext_dist(a.distance) + rsc_pkg::zext_dist(item.link_dist)
              + rsc_pkg::zext_dist(b.distance);
    dur_sum   = rsc_pkg::zext_dur(a.dur) + rsc_pkg::zext_dur(item.link_dur)
              + rsc_pkg::zext_dur(b.dur);

    joined.load     = rsc_pkg::sat_load(load_sum);
    joined.peak     = rsc_pkg::sat_load((peak_a > peak_alt) ? peak_a : peak_alt);
    joined.ok       = a.ok && b.ok && (ef_arrive <= lb_b);
    joined.ef       = rsc_pkg::sat_time((ef_sum > ef_b) ? ef_sum : ef_b);
    joined.lb       = rsc_pkg::sat_time((lb_a < lb_diff) ? lb_a : lb_diff);
    joined.distance = rsc_pkg::sat_dist(dist_sum);
    joined.dur      = rsc_pkg::sat_dur(dur_sum);
  end

  // operation select, unused code keeps the summary
  always_comb begin
    unique case (func)
      rsc_pkg::FUNC_LOAD:    next_seg = item.seg;
      rsc_pkg::FUNC_APPEND:  next_seg = joined;
      rsc_pkg::FUNC_PREPEND: next_seg = joined;
      default:               next_seg = kept;
    endcase
  end

endmodule

>>> design/route_segment_concat.sv
// route segment concatenation
// keeps one route summary; each beat loads, appends or prepends one segment.
// input stream s_*: tuser carries func (load, append, prepend), tdata the item
// segment summary and the joining edge. output stream m_*: tdata carries the
// new kept summary, one result beat for every input beat, in order.
// path: an accepted beat is held in the input register, combined with the
// kept summary and written to the result register, which raises m_tvalid.
// throughput: one beat per cycle while m_* is not stalled; the kept summary is
// the result register and feeds the next combine directly, so back-to-back
// beats chain without gaps. the adder, compare and clamp logic between the
// input register and the result register sets the clock-to-clock path.
// stall: while m_tvalid is high and m_tready low, the result holds, one more
// beat may wait in the input register, then s_tready drops.
// reset: both registers empty; kept summary returns to zero load, peak,
// distance, duration and earliest finish, latest begin at the most positive
// value and the window flag set.
module route_segment_concat (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // lsb up: item_load, item_peak_load, item_distance, item_duration,
  // item_earliest_finish, item_latest_begin, item_window_ok,
  // edge_duration, edge_distance, zero pad
  input  logic [rsc_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [rsc_pkg::FUNC_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // lsb up: out_load, out_peak_load, out_distance, out_duration,
  // out_earliest_finish, out_latest_begin, out_window_ok
  output logic [rsc_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam rsc_pkg::seg_t KEPT_RESET = '{
    ok:       1'b1,
    lb:       {1'b0, {(rsc_pkg::TIME_BITS-1){1'b1}}},
    ef:       '0,
    dur:      '0,
    distance: '0,
    peak:     '0,
    load:     '0
  };

  rsc_pkg::stage_t stg;
  rsc_pkg::seg_t   kept;
  rsc_pkg::seg_t   kept_next;
  logic            advance;

  // move the held beat when the result slot frees up
  assign advance = stg.valid && (!m_tvalid || m_tready);

  rsc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (advance),
    .stg      (stg)
  );

  rsc_join u_join (
    .func     (stg.func),
    .item     (stg.item),
    .kept     (kept),
    .next_seg (kept_next)
  );

  // kept summary doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      kept     <= KEPT_RESET;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      kept     <= kept_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = rsc_pkg::OUT_DATA_W'(kept);

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("registers not empty after reset");

  // kept summary only moves with a beat
  a_kept_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(kept))
    else $error("kept summary changed without a beat");

  // load replaces the summary with the item
  a_load_copy: assert property (@(posedge clk) disable iff (rst)
    advance && stg.func == rsc_pkg::FUNC_LOAD |=> kept == $past(stg.item.seg))
    else $error("load did not copy the item segment");

  // input side only stalls while a beat is held
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> stg.valid && m_tvalid && !m_tready)
    else $error("input stalled with room to take a beat");

endmodule
